### hw/rtl/pdr_pkg.sv
// shared types, constants and helpers of the particle density relaxation block
// no dependencies; used by every module of the block

package pdr_pkg;

  localparam int unsigned PARTICLES_DEF = 64;

  // field and datapath widths
  localparam int unsigned POS_W     = 24;
  localparam int unsigned MEM_W     = 2 * POS_W;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned DX_W      = 25;
  localparam int unsigned MUL_A_W   = 36;
  localparam int unsigned MUL_B_W   = 26;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned ROOT_W    = 52;
  localparam int unsigned DIV_W     = 60;
  localparam int unsigned DEN_W     = 32;
  localparam int unsigned Q_W       = 17;
  localparam int unsigned QQ_W      = 33;
  localparam int unsigned SUM_W     = 22;
  localparam int unsigned PRES_W    = 33;
  localparam int unsigned NP_W      = 30;
  localparam int unsigned INNER_W   = 35;
  localparam int unsigned HALF_W    = 52;
  localparam int unsigned ACC_W     = 58;
  localparam int unsigned SAT_W     = 60;
  localparam int unsigned STEP_W    = 6;
  localparam int unsigned ROOT_STEPS = 26;
  localparam int unsigned DIV_STEPS  = 60;

  // configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 24;
  localparam int unsigned DT_W      = 16;
  localparam int unsigned RAD_W     = 23;
  localparam int unsigned K_W       = 24;

  localparam logic [DT_W-1:0]  DT_RST   = 16'd1092;
  localparam logic [RAD_W-1:0] RAD_RST  = 23'd4096;
  localparam logic [K_W-1:0]   K_RST    = 24'd32768;
  localparam logic [K_W-1:0]   KN_RST   = 24'd65536;
  localparam logic [K_W-1:0]   D0_RST   = 24'd655360;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP    = 3'd0,
    CFG_RADIUS       = 3'd1,
    CFG_STIFFNESS    = 3'd2,
    CFG_NEAR_STIFF   = 3'd3,
    CFG_REST_DENSITY = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    last;
  } pdr_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] new_x;
    logic signed [POS_W-1:0] new_y;
    logic [IDX_W-1:0]        particle_index;
    logic                    final_res;
  } pdr_res_t;

  typedef enum logic [5:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_DT,
    OP_SET_DT2,
    OP_LD_I,
    OP_LD_J,
    OP_MUL_UX,
    OP_MUL_UY,
    OP_RT_INIT,
    OP_RT_STEP,
    OP_QD_INIT,
    OP_DIV_STEP,
    OP_SET_Q,
    OP_MUL_QQ,
    OP_ACC_DN,
    OP_MUL_QQQ,
    OP_ACC_NR,
    OP_MUL_P,
    OP_SET_P,
    OP_MUL_NP,
    OP_SET_NP,
    OP_SET_Q2,
    OP_MUL_PQ,
    OP_SET_IN,
    OP_MUL_NQ,
    OP_ADD_IN,
    OP_MUL_F,
    OP_SET_F,
    OP_MUL_HX,
    OP_MUL_HY,
    OP_HD_INIT,
    OP_SET_HX,
    OP_SET_HY,
    OP_WR_J,
    OP_WR_I,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   is_last;
  } pdr_cmd_t;

  typedef struct packed {
    logic in_range;
    logic dist_zero;
  } pdr_status_t;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_DT_MUL,
    ST_DT_SET,
    ST_I_RD,
    ST_I_LD,
    ST_J_RD,
    ST_J_LD,
    ST_SQ_X,
    ST_SQ_Y,
    ST_RT_INIT,
    ST_RT_STEP,
    ST_CHK,
    ST_QD_INIT,
    ST_QD_STEP,
    ST_QD_SET,
    ST_QQ_MUL,
    ST_DN_ACC,
    ST_QQQ_MUL,
    ST_NR_ACC,
    ST_J_NEXT,
    ST_P_MUL,
    ST_P_SET,
    ST_NP_MUL,
    ST_NP_SET,
    ST_Q2_SET,
    ST_PQ_MUL,
    ST_IN_SET,
    ST_NQ_MUL,
    ST_IN_ADD,
    ST_F_MUL,
    ST_F_SET,
    ST_HX_MUL,
    ST_HX_INIT,
    ST_HX_STEP,
    ST_HX_SET,
    ST_HY_MUL,
    ST_HY_INIT,
    ST_HY_STEP,
    ST_HY_SET,
    ST_WR_J,
    ST_WR_I,
    ST_EM_RD,
    ST_EM_CAP
  } ctl_state_e;

  // clamp a wide signed sum to the position range
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(signed'(24'sh7fffff));
    lo = SAT_W'(signed'(24'sh800000));
    if (v > hi) begin
      sat_pos = 24'sh7fffff;
    end else if (v < lo) begin
      sat_pos = 24'sh800000;
    end else begin
      sat_pos = v[POS_W-1:0];
    end
  endfunction

endpackage

### hw/rtl/pdr_ram.sv
// generic single write port ram with one registered read port
// no dependencies beyond the package defaults

module pdr_ram #(
  parameter int unsigned WIDTH = pdr_pkg::MEM_W,
  parameter int unsigned DEPTH = pdr_pkg::PARTICLES_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/pdr_ctrl.sv
// sequencer of the relaxation pass: load, pair loops, iteration counts, emission
// depends on pdr_pkg

module pdr_ctrl #(
  parameter int unsigned PARTICLES = pdr_pkg::PARTICLES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         last_i,
  input  pdr_pkg::pdr_status_t         status_i,
  output pdr_pkg::pdr_cmd_t            cmd_o,
  output logic [$clog2(PARTICLES)-1:0] mem_addr_o,
  output logic                         busy_o,
  output logic                         res_valid_o
);
  import pdr_pkg::*;

  localparam int unsigned AW = $clog2(PARTICLES);
  localparam int unsigned CW = $clog2(PARTICLES + 1);

  ctl_state_e         state_q, state_d;
  logic [AW-1:0]      i_q, i_d;
  logic [AW-1:0]      j_q, j_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               push_q, push_d;
  logic               valid_q, valid_d;
  logic               j_last;
  logic               i_last;

  assign j_last = (({1'b0, j_q} + (AW+1)'(1)) == (AW+1)'(cnt_q));
  assign i_last = (({1'b0, i_q} + (AW+1)'(1)) == (AW+1)'(cnt_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      cnt_q   <= '0;
      step_q  <= '0;
      push_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
      push_q  <= push_d;
      valid_q <= valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    cnt_d      = cnt_q;
    step_d     = step_q;
    push_d     = push_q;
    valid_d    = 1'b0;
    cmd_o      = '{op: OP_NONE, is_last: 1'b0};
    mem_addr_o = j_q;
    case (state_q)
      ST_IDLE: begin
        mem_addr_o = cnt_q[AW-1:0];
        if (start_i) begin
          if (cnt_q < CW'(PARTICLES)) begin
            cmd_o.op = OP_LOAD;
            cnt_d    = cnt_q + CW'(1);
          end
          if (last_i) begin
            state_d = ST_DT_MUL;
          end
        end
      end
      ST_DT_MUL: begin
        cmd_o.op = OP_MUL_DT;
        state_d  = ST_DT_SET;
      end
      ST_DT_SET: begin
        cmd_o.op = OP_SET_DT2;
        i_d      = '0;
        state_d  = ST_I_RD;
      end
      ST_I_RD: begin
        mem_addr_o = i_q;
        state_d    = ST_I_LD;
      end
      ST_I_LD: begin
        cmd_o.op = OP_LD_I;
        j_d      = '0;
        push_d   = 1'b0;
        state_d  = ST_J_RD;
      end
      ST_J_RD: begin
        if (j_q == i_q) begin
          state_d = ST_J_NEXT;
        end else begin
          state_d = ST_J_LD;
        end
      end
      ST_J_LD: begin
        cmd_o.op = OP_LD_J;
        state_d  = ST_SQ_X;
      end
      ST_SQ_X: begin
        cmd_o.op = OP_MUL_UX;
        state_d  = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        cmd_o.op = OP_MUL_UY;
        state_d  = ST_RT_INIT;
      end
      ST_RT_INIT: begin
        cmd_o.op = OP_RT_INIT;
        step_d   = '0;
        state_d  = ST_RT_STEP;
      end
      ST_RT_STEP: begin
        cmd_o.op = OP_RT_STEP;
        if (step_q == STEP_W'(ROOT_STEPS - 1)) begin
          step_d  = '0;
          state_d = ST_CHK;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_CHK: begin
        if (status_i.in_range && !(push_q && status_i.dist_zero)) begin
          state_d = ST_QD_INIT;
        end else begin
          state_d = ST_J_NEXT;
        end
      end
      ST_QD_INIT: begin
        cmd_o.op = OP_QD_INIT;
        step_d   = '0;
        state_d  = ST_QD_STEP;
      end
      ST_QD_STEP: begin
        cmd_o.op = OP_DIV_STEP;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          step_d  = '0;
          state_d = ST_QD_SET;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_QD_SET: begin
        cmd_o.op = OP_SET_Q;
        state_d  = ST_QQ_MUL;
      end
      ST_QQ_MUL: begin
        cmd_o.op = OP_MUL_QQ;
        state_d  = push_q ? ST_Q2_SET : ST_DN_ACC;
      end
      ST_DN_ACC: begin
        cmd_o.op = OP_ACC_DN;
        state_d  = ST_QQQ_MUL;
      end
      ST_QQQ_MUL: begin
        cmd_o.op = OP_MUL_QQQ;
        state_d  = ST_NR_ACC;
      end
      ST_NR_ACC: begin
        cmd_o.op = OP_ACC_NR;
        state_d  = ST_J_NEXT;
      end
      ST_J_NEXT: begin
        if (j_last) begin
          state_d = push_q ? ST_WR_I : ST_P_MUL;
        end else begin
          j_d     = j_q + AW'(1);
          state_d = ST_J_RD;
        end
      end
      ST_P_MUL: begin
        cmd_o.op = OP_MUL_P;
        state_d  = ST_P_SET;
      end
      ST_P_SET: begin
        cmd_o.op = OP_SET_P;
        state_d  = ST_NP_MUL;
      end
      ST_NP_MUL: begin
        cmd_o.op = OP_MUL_NP;
        state_d  = ST_NP_SET;
      end
      ST_NP_SET: begin
        cmd_o.op = OP_SET_NP;
        push_d   = 1'b1;
        j_d      = '0;
        state_d  = ST_J_RD;
      end
      ST_Q2_SET: begin
        cmd_o.op = OP_SET_Q2;
        state_d  = ST_PQ_MUL;
      end
      ST_PQ_MUL: begin
        cmd_o.op = OP_MUL_PQ;
        state_d  = ST_IN_SET;
      end
      ST_IN_SET: begin
        cmd_o.op = OP_SET_IN;
        state_d  = ST_NQ_MUL;
      end
      ST_NQ_MUL: begin
        cmd_o.op = OP_MUL_NQ;
        state_d  = ST_IN_ADD;
      end
      ST_IN_ADD: begin
        cmd_o.op = OP_ADD_IN;
        state_d  = ST_F_MUL;
      end
      ST_F_MUL: begin
        cmd_o.op = OP_MUL_F;
        state_d  = ST_F_SET;
      end
      ST_F_SET: begin
        cmd_o.op = OP_SET_F;
        state_d  = ST_HX_MUL;
      end
      ST_HX_MUL: begin
        cmd_o.op = OP_MUL_HX;
        state_d  = ST_HX_INIT;
      end
      ST_HX_INIT: begin
        cmd_o.op = OP_HD_INIT;
        step_d   = '0;
        state_d  = ST_HX_STEP;
      end
      ST_HX_STEP: begin
        cmd_o.op = OP_DIV_STEP;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          step_d  = '0;
          state_d = ST_HX_SET;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_HX_SET: begin
        cmd_o.op = OP_SET_HX;
        state_d  = ST_HY_MUL;
      end
      ST_HY_MUL: begin
        cmd_o.op = OP_MUL_HY;
        state_d  = ST_HY_INIT;
      end
      ST_HY_INIT: begin
        cmd_o.op = OP_HD_INIT;
        step_d   = '0;
        state_d  = ST_HY_STEP;
      end
      ST_HY_STEP: begin
        cmd_o.op = OP_DIV_STEP;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          step_d  = '0;
          state_d = ST_HY_SET;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_HY_SET: begin
        cmd_o.op = OP_SET_HY;
        state_d  = ST_WR_J;
      end
      ST_WR_J: begin
        cmd_o.op = OP_WR_J;
        state_d  = ST_J_NEXT;
      end
      ST_WR_I: begin
        cmd_o.op   = OP_WR_I;
        mem_addr_o = i_q;
        push_d     = 1'b0;
        if (i_last) begin
          i_d     = '0;
          state_d = ST_EM_RD;
        end else begin
          i_d     = i_q + AW'(1);
          state_d = ST_I_RD;
        end
      end
      ST_EM_RD: begin
        mem_addr_o = i_q;
        state_d    = ST_EM_CAP;
      end
      ST_EM_CAP: begin
        cmd_o.op      = OP_EMIT;
        cmd_o.is_last = i_last;
        mem_addr_o    = i_q;
        valid_d       = 1'b1;
        if (i_last) begin
          cnt_d   = '0;
          i_d     = '0;
          state_d = ST_IDLE;
        end else begin
          i_d     = i_q + AW'(1);
          state_d = ST_EM_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = valid_q;

endmodule

### hw/rtl/pdr_dpath.sv
// datapath: config registers, position store, shared multiplier, root and divider
// depends on pdr_pkg and pdr_ram

module pdr_dpath #(
  parameter int unsigned PARTICLES = pdr_pkg::PARTICLES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pdr_pkg::pdr_cmd_t                  cmd_i,
  input  logic [$clog2(PARTICLES)-1:0]       mem_addr_i,
  input  pdr_pkg::pdr_in_t                   in_i,
  input  logic                               cfg_we_i,
  input  logic [pdr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pdr_pkg::CFG_W-1:0]          cfg_wdata_i,
  output pdr_pkg::pdr_status_t               status_o,
  output pdr_pkg::pdr_res_t                  res_o
);
  import pdr_pkg::*;

  // configuration
  logic [DT_W-1:0]  dt_q;
  logic [RAD_W-1:0] radius_q;
  logic [K_W-1:0]   k_q, kn_q, d0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q     <= DT_RST;
      radius_q <= RAD_RST;
      k_q      <= K_RST;
      kn_q     <= KN_RST;
      d0_q     <= D0_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TIME_STEP:    dt_q     <= cfg_wdata_i[DT_W-1:0];
        CFG_RADIUS:       radius_q <= cfg_wdata_i[RAD_W-1:0];
        CFG_STIFFNESS:    k_q      <= cfg_wdata_i[K_W-1:0];
        CFG_NEAR_STIFF:   kn_q     <= cfg_wdata_i[K_W-1:0];
        CFG_REST_DENSITY: d0_q     <= cfg_wdata_i[K_W-1:0];
        default: ;
      endcase
    end
  end

  // position store
  logic                    mem_we;
  logic [MEM_W-1:0]        mem_wdata;
  logic [MEM_W-1:0]        mem_rdata;
  logic signed [POS_W-1:0] rd_x, rd_y;

  pdr_ram #(
    .WIDTH (MEM_W),
    .DEPTH (PARTICLES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr_i),
    .wdata_i (mem_wdata),
    .raddr_i (mem_addr_i),
    .rdata_o (mem_rdata)
  );

  assign rd_x = $signed(mem_rdata[MEM_W-1:POS_W]);
  assign rd_y = $signed(mem_rdata[POS_W-1:0]);

  // working registers
  logic signed [POS_W-1:0]   xi_q, yi_q, xj_q, yj_q;
  logic signed [POS_W-1:0]   xi_d, yi_d, xj_d, yj_d;
  logic signed [DX_W-1:0]    dx_q, dy_q, dx_d, dy_d;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic [ROOT_W-1:0]         rad_q, rad_d;
  logic [ROOT_W-1:0]         rt_v_q, rt_root_q, rt_bit_q;
  logic [ROOT_W-1:0]         rt_v_d, rt_root_d, rt_bit_d;
  logic [DIV_W-1:0]          div_num_q, div_num_d;
  logic [DEN_W-1:0]          div_rem_q, div_den_q, div_rem_d, div_den_d;
  logic                      div_neg_q, div_neg_d;
  logic [DT_W-1:0]           dt2_q, dt2_d;
  logic [Q_W-1:0]            q_q, q2_q, q_d, q2_d;
  logic [QQ_W-1:0]           qq_q, qq_d;
  logic [SUM_W-1:0]          dens_q, near_q, dens_d, near_d;
  logic signed [PRES_W-1:0]  pres_q, pres_d;
  logic [NP_W-1:0]           np_q, np_d;
  logic signed [INNER_W-1:0] inner_q, inner_d, factor_q, factor_d;
  logic signed [HALF_W-1:0]  hx_q, hy_q, hx_d, hy_d;
  logic signed [ACC_W-1:0]   acc_x_q, acc_y_q, acc_x_d, acc_y_d;
  pdr_res_t                  res_q, res_d;

  // combinational helpers
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic [DX_W-1:0]           ux, uy;
  logic signed [DX_W-1:0]    dens_diff;
  logic [ROOT_W-1:0]         rt_trial;
  logic [DEN_W:0]            div_trial;
  logic                      div_ge;
  logic [PROD_W-1:0]         prod_mag;
  logic signed [HALF_W-1:0]  quo_s;
  logic [RAD_W-1:0]          root_dist;
  logic signed [POS_W-1:0]   new_xj, new_yj, new_xi, new_yi;

  assign ux        = dx_q[DX_W-1] ? DX_W'(-dx_q) : DX_W'(dx_q);
  assign uy        = dy_q[DX_W-1] ? DX_W'(-dy_q) : DX_W'(dy_q);
  assign dens_diff = $signed({3'b0, dens_q}) - $signed({1'b0, d0_q});
  assign rt_trial  = rt_root_q + rt_bit_q;
  assign div_trial = {div_rem_q, div_num_q[DIV_W-1]};
  assign div_ge    = (div_trial >= {1'b0, div_den_q});
  assign prod_mag  = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
  assign quo_s     = $signed({1'b0, div_num_q[HALF_W-2:0]});
  assign root_dist = rt_root_q[RAD_W-1:0];
  assign new_xj    = sat_pos(SAT_W'(xj_q) + SAT_W'(hx_q));
  assign new_yj    = sat_pos(SAT_W'(yj_q) + SAT_W'(hy_q));
  assign new_xi    = sat_pos(SAT_W'(xi_q) + SAT_W'(acc_x_q));
  assign new_yi    = sat_pos(SAT_W'(yi_q) + SAT_W'(acc_y_q));

  assign status_o.in_range  = (rt_root_q < ROOT_W'(radius_q));
  assign status_o.dist_zero = (rt_root_q == '0);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_MUL_DT: begin
        mul_a = MUL_A_W'({1'b0, dt_q});
        mul_b = MUL_B_W'({1'b0, dt_q});
      end
      OP_MUL_UX: begin
        mul_a = MUL_A_W'({1'b0, ux});
        mul_b = MUL_B_W'({1'b0, ux});
      end
      OP_MUL_UY: begin
        mul_a = MUL_A_W'({1'b0, uy});
        mul_b = MUL_B_W'({1'b0, uy});
      end
      OP_MUL_QQ: begin
        mul_a = MUL_A_W'({1'b0, q_q});
        mul_b = MUL_B_W'({1'b0, q_q});
      end
      OP_MUL_QQQ: begin
        mul_a = MUL_A_W'({1'b0, qq_q});
        mul_b = MUL_B_W'({1'b0, q_q});
      end
      OP_MUL_P: begin
        mul_a = MUL_A_W'(dens_diff);
        mul_b = MUL_B_W'({1'b0, k_q});
      end
      OP_MUL_NP: begin
        mul_a = MUL_A_W'({1'b0, near_q});
        mul_b = MUL_B_W'({1'b0, kn_q});
      end
      OP_MUL_PQ: begin
        mul_a = MUL_A_W'(pres_q);
        mul_b = MUL_B_W'({1'b0, q_q});
      end
      OP_MUL_NQ: begin
        mul_a = MUL_A_W'({1'b0, np_q});
        mul_b = MUL_B_W'({1'b0, q2_q});
      end
      OP_MUL_F: begin
        mul_a = MUL_A_W'(inner_q);
        mul_b = MUL_B_W'({1'b0, dt2_q});
      end
      OP_MUL_HX: begin
        mul_a = MUL_A_W'(factor_q);
        mul_b = MUL_B_W'(dx_q);
      end
      OP_MUL_HY: begin
        mul_a = MUL_A_W'(factor_q);
        mul_b = MUL_B_W'(dy_q);
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // register updates per command
  always_comb begin
    xi_d      = xi_q;
    yi_d      = yi_q;
    xj_d      = xj_q;
    yj_d      = yj_q;
    dx_d      = dx_q;
    dy_d      = dy_q;
    rad_d     = rad_q;
    rt_v_d    = rt_v_q;
    rt_root_d = rt_root_q;
    rt_bit_d  = rt_bit_q;
    div_num_d = div_num_q;
    div_rem_d = div_rem_q;
    div_den_d = div_den_q;
    div_neg_d = div_neg_q;
    dt2_d     = dt2_q;
    q_d       = q_q;
    q2_d      = q2_q;
    qq_d      = qq_q;
    dens_d    = dens_q;
    near_d    = near_q;
    pres_d    = pres_q;
    np_d      = np_q;
    inner_d   = inner_q;
    factor_d  = factor_q;
    hx_d      = hx_q;
    hy_d      = hy_q;
    acc_x_d   = acc_x_q;
    acc_y_d   = acc_y_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_wdata = {in_i.pos_x, in_i.pos_y};
    case (cmd_i.op)
      OP_LOAD: begin
        mem_we = 1'b1;
      end
      OP_SET_DT2: begin
        dt2_d = prod_q[31:16];
      end
      OP_LD_I: begin
        xi_d    = rd_x;
        yi_d    = rd_y;
        dens_d  = '0;
        near_d  = '0;
        acc_x_d = '0;
        acc_y_d = '0;
      end
      OP_LD_J: begin
        xj_d = rd_x;
        yj_d = rd_y;
        dx_d = DX_W'(rd_x) - DX_W'(xi_q);
        dy_d = DX_W'(rd_y) - DX_W'(yi_q);
      end
      OP_MUL_UY: begin
        rad_d = ROOT_W'(prod_q[49:0]);
      end
      OP_RT_INIT: begin
        rt_v_d    = rad_q + ROOT_W'(prod_q[49:0]);
        rt_root_d = '0;
        rt_bit_d  = ROOT_W'(1) << 50;
      end
      OP_RT_STEP: begin
        if (rt_v_q >= rt_trial) begin
          rt_v_d    = rt_v_q - rt_trial;
          rt_root_d = (rt_root_q >> 1) + rt_bit_q;
        end else begin
          rt_root_d = rt_root_q >> 1;
        end
        rt_bit_d = rt_bit_q >> 2;
      end
      OP_QD_INIT: begin
        div_num_d = DIV_W'({radius_q - root_dist, 16'b0});
        div_den_d = DEN_W'(radius_q);
        div_rem_d = '0;
        div_neg_d = 1'b0;
      end
      OP_HD_INIT: begin
        div_num_d = prod_mag[DIV_W-1:0];
        div_den_d = {root_dist, 9'b0};
        div_rem_d = '0;
        div_neg_d = prod_q[PROD_W-1];
      end
      OP_DIV_STEP: begin
        div_rem_d = div_ge ? DEN_W'(div_trial - {1'b0, div_den_q}) : div_trial[DEN_W-1:0];
        div_num_d = {div_num_q[DIV_W-2:0], div_ge};
      end
      OP_SET_Q: begin
        q_d = div_num_q[Q_W-1:0];
      end
      OP_ACC_DN: begin
        dens_d = dens_q + SUM_W'(prod_q[32:16]);
        qq_d   = prod_q[QQ_W-1:0];
      end
      OP_ACC_NR: begin
        near_d = near_q + SUM_W'(prod_q[48:32]);
      end
      OP_SET_P: begin
        pres_d = $signed(prod_q[48:16]);
      end
      OP_SET_NP: begin
        np_d = prod_q[45:16];
      end
      OP_SET_Q2: begin
        q2_d = prod_q[32:16];
      end
      OP_SET_IN: begin
        inner_d = $signed(prod_q[50:16]);
      end
      OP_ADD_IN: begin
        inner_d = inner_q + $signed(prod_q[50:16]);
      end
      OP_SET_F: begin
        factor_d = $signed(prod_q[50:16]);
      end
      OP_SET_HX: begin
        hx_d = div_neg_q ? -quo_s : quo_s;
      end
      OP_SET_HY: begin
        hy_d = div_neg_q ? -quo_s : quo_s;
      end
      OP_WR_J: begin
        mem_we    = 1'b1;
        mem_wdata = {new_xj, new_yj};
        acc_x_d   = acc_x_q - ACC_W'(hx_q);
        acc_y_d   = acc_y_q - ACC_W'(hy_q);
      end
      OP_WR_I: begin
        mem_we    = 1'b1;
        mem_wdata = {new_xi, new_yi};
      end
      OP_EMIT: begin
        res_d.new_x          = rd_x;
        res_d.new_y          = rd_y;
        res_d.particle_index = IDX_W'(mem_addr_i);
        res_d.final_res      = cmd_i.is_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    xi_q      <= xi_d;
    yi_q      <= yi_d;
    xj_q      <= xj_d;
    yj_q      <= yj_d;
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    prod_q    <= prod_d;
    rad_q     <= rad_d;
    rt_v_q    <= rt_v_d;
    rt_root_q <= rt_root_d;
    rt_bit_q  <= rt_bit_d;
    div_num_q <= div_num_d;
    div_rem_q <= div_rem_d;
    div_den_q <= div_den_d;
    div_neg_q <= div_neg_d;
    dt2_q     <= dt2_d;
    q_q       <= q_d;
    q2_q      <= q2_d;
    qq_q      <= qq_d;
    dens_q    <= dens_d;
    near_q    <= near_d;
    pres_q    <= pres_d;
    np_q      <= np_d;
    inner_q   <= inner_d;
    factor_q  <= factor_d;
    hx_q      <= hx_d;
    hy_q      <= hy_d;
    acc_x_q   <= acc_x_d;
    acc_y_q   <= acc_y_d;
    res_q     <= res_d;
  end

  assign res_o = res_q;

endmodule

### hw/rtl/particle_density_relaxation.sv
// top level of the particle density relaxation block
// depends on pdr_pkg, pdr_ctrl, pdr_dpath (which holds pdr_ram)
//
//   channel   handshake               word
//   --------  ----------------------  --------------------------------------
//   input     start_i high, busy_o    in_i: pos_x, pos_y, last
//             low at the clock edge
//   result    res_valid_o, one cycle  res_o: new_x, new_y, particle_index,
//                                     final_res
//   config    cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// busy_o stays low until a word marked last arrives. the relaxation pass
// then runs a density sweep and a push sweep over every ordered pair, with
// less work for a pair outside the radius; the 60-step divider and 26-step
// root set most of its length. results follow one word at a time, and the
// receiver cannot stall. reset clears the sequencer and config; the position
// store holds no reset.

module particle_density_relaxation #(
  parameter int unsigned PARTICLES = pdr_pkg::PARTICLES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  pdr_pkg::pdr_in_t              in_i,
  output logic                          res_valid_o,
  output pdr_pkg::pdr_res_t             res_o,
  input  logic                          cfg_we_i,
  input  logic [pdr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pdr_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import pdr_pkg::*;

  // command and status between sequencer and datapath
  pdr_cmd_t                     cmd;
  pdr_status_t                  status;
  logic [$clog2(PARTICLES)-1:0] mem_addr;

  // sequencer: load count, pair loops, step counts, result strobe
  pdr_ctrl #(
    .PARTICLES (PARTICLES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .last_i      (in_i.last),
    .status_i    (status),
    .cmd_o       (cmd),
    .mem_addr_o  (mem_addr),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o)
  );

  // datapath: store, shared multiplier, root and divider, result register
  pdr_dpath #(
    .PARTICLES (PARTICLES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .mem_addr_i  (mem_addr),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .status_o    (status),
    .res_o       (res_o)
  );

endmodule

### sim/pdr_checker.sv
// result checker for particle_density_relaxation: tracks accepted words and config writes,
// recomputes the relaxation pass and compares every result word; needs only pdr_pkg
`timescale 1ns / 1ps

module pdr_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_o,
  input  pdr_pkg::pdr_in_t              in_i,
  input  logic                          res_valid_o,
  input  pdr_pkg::pdr_res_t             res_o,
  input  logic                          cfg_we_i,
  input  logic [pdr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pdr_pkg::CFG_W-1:0]     cfg_wdata_i,
  output int                            fail_count,
  output int                            pending
);
  import pdr_pkg::*;

  localparam int SET_MAX = PARTICLES_DEF;

  longint unsigned dt_q, rad_q, k_q, kn_q, d0_q;
  longint          px [SET_MAX];
  longint          py [SET_MAX];
  int              n_loaded;
  pdr_res_t        relaxed_q [$];

  assign pending = relaxed_q.size();

  function automatic longint clamp_pos(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 50;
    for (int k = 0; k < ROOT_STEPS; k++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // distance from a to b under the current, partly updated positions
  function automatic longint unsigned sep(int a, int b, output longint dx, output longint dy);
    longint unsigned ux;
    longint unsigned uy;
    dx = px[b] - px[a];
    dy = py[b] - py[a];
    ux = (dx < 0) ? -dx : dx;
    uy = (dy < 0) ? -dy : dy;
    return floor_root(ux * ux + uy * uy);
  endfunction

  task automatic relax_set(int n);
    longint dt2, dx, dy, pres, near_p, ax, ay, inner, factor, hx, hy;
    longint unsigned dens, near_sum, d, q, q2;
    dt2 = longint'((dt_q * dt_q) >> 16);
    for (int i = 0; i < n; i++) begin
      dens = 0;
      near_sum = 0;
      ax = 0;
      ay = 0;
      for (int j = 0; j < n; j++) begin
        if (j == i) continue;
        d = sep(i, j, dx, dy);
        if (d >= rad_q) continue;
        q = ((rad_q - d) << 16) / rad_q;
        dens += (q * q) >> 16;
        near_sum += (q * q * q) >> 32;
      end
      pres = (longint'(k_q) * (longint'(dens) - longint'(d0_q))) >>> 16;
      near_p = longint'((kn_q * near_sum) >> 16);
      for (int j = 0; j < n; j++) begin
        if (j == i) continue;
        d = sep(i, j, dx, dy);
        // coincident pairs count toward density but get no push
        if (d >= rad_q || d == 0) continue;
        q = ((rad_q - d) << 16) / rad_q;
        q2 = (q * q) >> 16;
        inner = ((pres * longint'(q)) >>> 16) + ((near_p * longint'(q2)) >>> 16);
        factor = (inner * dt2) >>> 16;
        hx = (dx * factor) / longint'(d * 512);
        hy = (dy * factor) / longint'(d * 512);
        px[j] = clamp_pos(px[j] + hx);
        py[j] = clamp_pos(py[j] + hy);
        ax -= hx;
        ay -= hy;
      end
      px[i] = clamp_pos(px[i] + ax);
      py[i] = clamp_pos(py[i] + ay);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pdr_res_t w;
    pdr_res_t e;
    if (!rst_ni) begin
      dt_q = DT_RST;
      rad_q = RAD_RST;
      k_q = K_RST;
      kn_q = KN_RST;
      d0_q = D0_RST;
      n_loaded = 0;
      relaxed_q.delete();
      fail_count = 0;
    end else begin
      if (res_valid_o) begin
        w = res_o;
        if (relaxed_q.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, w);
          fail_count++;
        end else begin
          e = relaxed_q.pop_front();
          if (w.new_x !== e.new_x) begin
            $display("%0t: new_x expected %h actual %h", $time, e.new_x, w.new_x);
            fail_count++;
          end
          if (w.new_y !== e.new_y) begin
            $display("%0t: new_y expected %h actual %h", $time, e.new_y, w.new_y);
            fail_count++;
          end
          if (w.particle_index !== e.particle_index) begin
            $display("%0t: particle_index expected %0d actual %0d", $time,
                     e.particle_index, w.particle_index);
            fail_count++;
          end
          if (w.final_res !== e.final_res) begin
            $display("%0t: final_res expected %b actual %b", $time, e.final_res, w.final_res);
            fail_count++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_TIME_STEP:    dt_q = cfg_wdata_i[DT_W-1:0];
          CFG_RADIUS:       rad_q = cfg_wdata_i[RAD_W-1:0];
          CFG_STIFFNESS:    k_q = cfg_wdata_i;
          CFG_NEAR_STIFF:   kn_q = cfg_wdata_i;
          CFG_REST_DENSITY: d0_q = cfg_wdata_i;
          default: ;
        endcase
      end
      if (start_i && !busy_o) begin
        // a word past a full store is dropped, but its last flag still counts
        if (n_loaded < SET_MAX) begin
          px[n_loaded] = longint'(in_i.pos_x);
          py[n_loaded] = longint'(in_i.pos_y);
          n_loaded++;
        end
        if (in_i.last) begin
          relax_set(n_loaded);
          for (int k = 0; k < n_loaded; k++) begin
            e.new_x = 24'(px[k]);
            e.new_y = 24'(py[k]);
            e.particle_index = 6'(k);
            e.final_res = (k + 1 == n_loaded);
            relaxed_q.push_back(e);
          end
          n_loaded = 0;
        end
      end
    end
  end

endmodule

### sim/testbench.sv
// top of the particle_density_relaxation testbench: clock, reset, stimulus and verdict
// depends on pdr_pkg, the block and pdr_checker
`timescale 1ns / 1ps

module testbench;
  import pdr_pkg::*;

  // a full set with every pair in range keeps both channels quiet through its whole pass
  localparam int QUIET_LIMIT = 5000000;
  localparam int RANDOM_WORDS = 100;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  pdr_in_t              in_i = '0;
  logic                 res_valid_o;
  pdr_res_t             res_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  int                   fail_count;
  int                   pending;
  int                   gap_pct = 0;
  int                   quiet = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  particle_density_relaxation uut (.*);

  pdr_checker chk (.*);

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_valid_o) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // one load word; start stays high across back-to-back words
  task automatic send_word(int x, int y, bit last);
    bit taken;
    while ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i.pos_x <= 24'(x);
    in_i.pos_y <= 24'(y);
    in_i.last <= last;
    // busy only moves at the rising edge, so the falling edge gives its edge value
    do begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // let the set drain and the block go idle before touching config
  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, int unsigned v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= r;
    cfg_wdata_i <= CFG_W'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_config(int unsigned dt, int unsigned rad, int unsigned k,
                             int unsigned kn, int unsigned d0);
    write_reg(CFG_TIME_STEP, dt);
    write_reg(CFG_RADIUS, rad);
    write_reg(CFG_STIFFNESS, k);
    write_reg(CFG_NEAR_STIFF, kn);
    write_reg(CFG_REST_DENSITY, d0);
  endtask

  function automatic int clip24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return int'(v);
  endfunction

  initial begin
    int n, words, rad, cx, cy, sx, sy;
    bit noise;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // coincident pair plus a close neighbour, reset config
    send_word(0, 0, 0);
    send_word(0, 0, 0);
    send_word(1000, 0, 1);
    // position extremes
    send_word(8388607, 8388607, 0);
    send_word(-8388608, -8388608, 0);
    send_word(8388507, 8388607, 1);
    // a set of one
    send_word(123, -456, 1);
    settle();

    // zero radius: everything passes through
    write_reg(CFG_RADIUS, 0);
    send_word(10, 10, 0);
    send_word(-10, 20, 0);
    send_word(10, 10, 1);
    settle();

    // strongest settings, clustered near the top corner to hit saturation
    load_config(65535, 8388607, 24'hffffff, 24'hffffff, 0);
    send_word(8388000, 8388000, 0);
    send_word(8387000, 8388600, 0);
    send_word(-100, 300, 0);
    send_word(8388600, 8387500, 1);
    settle();

    // full store on a sparse grid, then a dropped word and a dropped last word
    load_config(1, 256, 0, 0, 24'hffffff);
    for (int k = 0; k < PARTICLES_DEF; k++) send_word((k % 8) * 1000 - 4000, (k / 8) * 1000, 0);
    send_word(77, 77, 0);
    send_word(-77, -77, 1);
    settle();

    words = 0;
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = (ph == 1) ? 78 : (ph == 3) ? 15 : 0;
      rad = $urandom_range(256, 20000);
      load_config($urandom_range(1, 65535), rad, $urandom_range(0, 24'hffffff) >> $urandom_range(0, 12),
                  $urandom_range(0, 24'hffffff) >> $urandom_range(0, 12),
                  $urandom_range(0, 24'hffffff) >> $urandom_range(0, 8));
      while (words < (ph + 1) * RANDOM_WORDS / 4) begin
        n = $urandom_range(2, 8);
        noise = ($urandom_range(99) < 20);
        cx = $urandom;
        cx = cx >>> 8;
        cy = $urandom;
        cy = cy >>> 8;
        for (int k = 0; k < n; k++) begin
          if (noise) begin
            sx = $urandom;
            sy = $urandom;
            sx = sx >>> 8;
            sy = sy >>> 8;
          end else begin
            // cluster within one radius of the centre on each axis so many pairs interact
            sx = clip24(longint'(cx) + $signed($urandom_range(0, 2 * rad)) - rad);
            sy = clip24(longint'(cy) + $signed($urandom_range(0, 2 * rad)) - rad);
          end
          send_word(sx, sy, k == n - 1);
          words++;
        end
      end
      settle();
    end

    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
